@@ rtl/lmtf_pkg.sv @@
// Shared constants and types for the move-to-front LRU cache.
// Used by lmtf_store, lmtf_ctrl and lru_move_to_front_cache; no dependencies.
`timescale 1ns / 1ps

package lmtf_pkg;

  localparam int unsigned ENTRIES  = 8;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 32;
  localparam int unsigned VAL_BITS = 64;

  // Key width actually stored: KEY_BITS capped at the tag field width.
  localparam int unsigned KeyW = (KEY_BITS < TAG_BITS) ? KEY_BITS : TAG_BITS;
  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  // Update of the recency list, applied to all slots at once.
  typedef struct packed {
    logic                en;      // apply the update
    logic                insert;  // new pair enters (count grows unless full)
    logic [IdxW-1:0]     pos;     // slots 1..pos take slot i-1
    logic [KeyW-1:0]     key;     // goes to slot 0
    logic [VAL_BITS-1:0] val;     // goes to slot 0
  } upd_t;

  // One result beat.
  typedef struct packed {
    logic                hit;
    logic                status;
    logic                evicted;
    logic [TAG_BITS-1:0] evicted_key;
    logic [VAL_BITS-1:0] value;
  } res_t;

endpackage

@@ rtl/lru_move_to_front_cache.sv @@
// Top level of the move-to-front LRU cache: stream ports and result register.
// Depends on lmtf_pkg, lmtf_store and lmtf_ctrl.
`timescale 1ns / 1ps

// Fully associative cache of lmtf_pkg::ENTRIES key/value pairs kept as a
// recency list packed from the front, where slot 0 is the most recently used.
// Each input beat carries a key tag, a fill value and a fill flag; each beat
// yields exactly one output beat. On a hit the stored value comes back and the
// entry moves to the front. On a miss with a good fill the pair is inserted at
// the front, and if the list was full the last entry is dropped and its key is
// reported. A miss with a failed fill reports status 1 and leaves the list
// untouched. Only the low KEY_BITS bits of the key tag take part in matching.
// Sequence: a request is taken in the idle state, then a single key comparator
// walks the filled slots from the front, one slot per cycle, stopping at the
// first match; the list update and the result register load then happen
// together in the final state, once the result register can take the beat.
// The block takes one request at a time; the result register lets the next
// request be accepted while the previous result still waits.
module lru_move_to_front_cache (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // [31:0] key_tag, [95:32] fill_value
  input  logic [0:0]   s_axis_tuser_i,   // [0] fill_ok
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,   // [63:0] value_out, [95:64] evicted_key
  output logic [2:0]   m_axis_tuser_o    // [0] hit, [1] status, [2] evicted
);

  logic [lmtf_pkg::IdxW-1:0]     rd_idx;
  logic [lmtf_pkg::KeyW-1:0]     rd_key;
  logic [lmtf_pkg::VAL_BITS-1:0] rd_val;
  logic [lmtf_pkg::KeyW-1:0]     last_key;
  logic [lmtf_pkg::CntW-1:0]     cnt;
  lmtf_pkg::upd_t                upd;
  lmtf_pkg::res_t                res;
  logic                          res_valid;
  logic                          res_ready;

  logic                          out_valid_q;
  lmtf_pkg::res_t                out_q;

  lmtf_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_key_o   (rd_key),
    .rd_val_o   (rd_val),
    .last_key_o (last_key),
    .cnt_o      (cnt),
    .upd_i      (upd)
  );

  lmtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_key_i   (s_axis_tdata_i[lmtf_pkg::KeyW-1:0]),
    .req_fill_i  (s_axis_tdata_i[95:32]),
    .req_ok_i    (s_axis_tuser_i[0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_idx_o    (rd_idx),
    .rd_key_i    (rd_key),
    .rd_val_i    (rd_val),
    .last_key_i  (last_key),
    .cnt_i       (cnt),
    .upd_o       (upd)
  );

  // The result register frees up in the same cycle its beat is taken.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.evicted_key, out_q.value};
  assign m_axis_tuser_o  = {out_q.evicted, out_q.status, out_q.hit};

endmodule

@@ rtl/lmtf_store.sv @@
// Entry storage of the move-to-front cache: key and value registers and a fill count.
// Depends on lmtf_pkg.
`timescale 1ns / 1ps

module lmtf_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lmtf_pkg::IdxW-1:0]     rd_idx_i,
  output logic [lmtf_pkg::KeyW-1:0]     rd_key_o,
  output logic [lmtf_pkg::VAL_BITS-1:0] rd_val_o,
  output logic [lmtf_pkg::KeyW-1:0]     last_key_o,
  output logic [lmtf_pkg::CntW-1:0]     cnt_o,
  input  lmtf_pkg::upd_t                upd_i
);

  logic [lmtf_pkg::KeyW-1:0]     keys_q [lmtf_pkg::ENTRIES];
  logic [lmtf_pkg::VAL_BITS-1:0] vals_q [lmtf_pkg::ENTRIES];
  logic [lmtf_pkg::CntW-1:0]     cnt_q, cnt_d;

  // Slots are packed from the front, so slot i is valid exactly when i < count.
  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      for (int unsigned i = 1; i < lmtf_pkg::ENTRIES; i++) begin
        if (lmtf_pkg::IdxW'(i) <= upd_i.pos) begin
          keys_q[i] <= keys_q[i-1];
          vals_q[i] <= vals_q[i-1];
        end
      end
      keys_q[0] <= upd_i.key;
      vals_q[0] <= upd_i.val;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (upd_i.en && upd_i.insert && (cnt_q != lmtf_pkg::CntW'(lmtf_pkg::ENTRIES))) begin
      cnt_d = cnt_q + lmtf_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign rd_key_o   = keys_q[rd_idx_i];
  assign rd_val_o   = vals_q[rd_idx_i];
  assign last_key_o = keys_q[lmtf_pkg::ENTRIES-1];
  assign cnt_o      = cnt_q;

endmodule

@@ rtl/lmtf_ctrl.sv @@
// Lookup sequencer: one shared key comparator walks the list slot by slot,
// then issues the list update and the result. Depends on lmtf_pkg.
`timescale 1ns / 1ps

module lmtf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [lmtf_pkg::KeyW-1:0]     req_key_i,
  input  logic [lmtf_pkg::VAL_BITS-1:0] req_fill_i,
  input  logic                          req_ok_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output lmtf_pkg::res_t                res_o,
  output logic [lmtf_pkg::IdxW-1:0]     rd_idx_o,
  input  logic [lmtf_pkg::KeyW-1:0]     rd_key_i,
  input  logic [lmtf_pkg::VAL_BITS-1:0] rd_val_i,
  input  logic [lmtf_pkg::KeyW-1:0]     last_key_i,
  input  logic [lmtf_pkg::CntW-1:0]     cnt_i,
  output lmtf_pkg::upd_t                upd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [lmtf_pkg::IdxW-1:0]     idx_q, idx_d;
  logic                          hit_q, hit_d;
  logic [lmtf_pkg::KeyW-1:0]     key_q;
  logic [lmtf_pkg::VAL_BITS-1:0] fill_q;
  logic                          ok_q;
  logic [lmtf_pkg::VAL_BITS-1:0] hval_q;
  logic                          match;
  logic                          last_slot;
  logic                          full;
  logic                          accept;

  assign accept    = req_valid_i && req_ready_o;
  assign match     = (rd_key_i == key_q);
  assign last_slot = ((lmtf_pkg::CntW'(idx_q) + lmtf_pkg::CntW'(1)) == cnt_i);
  assign full      = (cnt_i == lmtf_pkg::CntW'(lmtf_pkg::ENTRIES));
  assign rd_idx_o  = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = (cnt_i == '0) ? StFin : StScan;
        end
      end
      StScan: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = StFin;
        end else if (last_slot) begin
          state_d = StFin;
        end else begin
          idx_d = idx_q + lmtf_pkg::IdxW'(1);
        end
      end
      StFin: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= req_key_i;
      fill_q <= req_fill_i;
      ok_q   <= req_ok_i;
    end
    if ((state_q == StScan) && match) begin
      hval_q <= rd_val_i;
    end
  end

  assign req_ready_o = (state_q == StIdle);
  assign res_valid_o = (state_q == StFin);

  always_comb begin
    res_o.hit         = hit_q;
    res_o.status      = !hit_q && !ok_q;
    res_o.evicted     = !hit_q && ok_q && full;
    res_o.evicted_key = (!hit_q && ok_q && full) ? lmtf_pkg::TAG_BITS'(last_key_i) : '0;
    res_o.value       = hit_q ? hval_q : (ok_q ? fill_q : '0);

    upd_o.en     = res_valid_o && res_ready_i && (hit_q || ok_q);
    upd_o.insert = !hit_q;
    upd_o.pos    = hit_q ? idx_q : lmtf_pkg::IdxW'(lmtf_pkg::ENTRIES - 1);
    upd_o.key    = key_q;
    upd_o.val    = hit_q ? hval_q : fill_q;
  end

`ifndef SYNTH
  a_scan_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (lmtf_pkg::CntW'(idx_q) < cnt_i))
    else $error("scan index beyond filled slots");

  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_o.en |=> (cnt_i != '0))
    else $error("list empty after an update");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_i <= lmtf_pkg::CntW'(lmtf_pkg::ENTRIES))
    else $error("fill count exceeds entries");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit) |-> (!res_o.evicted && !res_o.status))
    else $error("hit reported with eviction or failure");
`endif

endmodule

@@ dv/lru_move_to_front_cache_test.sv @@
// Self-checking testbench for the move-to-front LRU cache: a queued stream driver,
// a checking monitor and a transaction-level model of the recency list.
// Depends on lmtf_pkg and lru_move_to_front_cache.
`timescale 1ns / 1ps

module lru_move_to_front_cache_test;

  // One request beat as the driver offers it, with its pacing.
  typedef struct {
    bit [lmtf_pkg::TAG_BITS-1:0] key;
    bit [lmtf_pkg::VAL_BITS-1:0] fill;
    bit                          ok;
    int                          gap;    // idle cycles before the beat is offered
    bit                          drain;  // hold the beat until every result is back
  } cache_request_t;

  // One result beat as the cache should return it.
  typedef struct {
    bit                          hit;
    bit                          status;
    bit                          evicted;
    bit [lmtf_pkg::TAG_BITS-1:0] evicted_key;
    bit [lmtf_pkg::VAL_BITS-1:0] value;
  } cache_result_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;   // [31:0] key_tag, [95:32] fill_value
  logic [0:0]  s_axis_tuser  = '0;   // [0] fill_ok
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;         // [63:0] value_out, [95:64] evicted_key
  logic [2:0]  m_axis_tuser;         // [0] hit, [1] status, [2] evicted

  lru_move_to_front_cache u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model of the recency list; slot 0 is the most recently used entry.
  bit [lmtf_pkg::KeyW-1:0]     lru_keys  [lmtf_pkg::ENTRIES];
  bit [lmtf_pkg::VAL_BITS-1:0] lru_values[lmtf_pkg::ENTRIES];
  bit                          lru_valid [lmtf_pkg::ENTRIES];

  cache_request_t request_q[$];
  cache_result_t  expected_results[$];
  int             mismatches = 0;
  int             results_seen = 0;

  // Looks the key up, updates the list as the cache must, and returns the
  // result beat that the request should produce.
  function automatic cache_result_t cache_lookup(bit [lmtf_pkg::TAG_BITS-1:0] key_tag,
                                                 bit [lmtf_pkg::VAL_BITS-1:0] fill, bit ok);
    cache_result_t               res;
    bit [lmtf_pkg::KeyW-1:0]     key;
    bit [lmtf_pkg::VAL_BITS-1:0] held;
    int                          found;
    res   = '{default: '0};
    key   = key_tag[lmtf_pkg::KeyW-1:0];
    found = -1;
    for (int i = 0; i < lmtf_pkg::ENTRIES && lru_valid[i]; i++) begin
      if (lru_keys[i] == key) begin
        found = i;
        break;
      end
    end
    if (found >= 0) begin
      // A hit ignores the fill fields and moves the entry to the front.
      held = lru_values[found];
      for (int i = found; i > 0; i--) begin
        lru_keys[i]   = lru_keys[i-1];
        lru_values[i] = lru_values[i-1];
      end
      lru_keys[0]   = key;
      lru_values[0] = held;
      res.hit       = 1'b1;
      res.value     = held;
    end else if (!ok) begin
      res.status = 1'b1;
    end else begin
      if (lru_valid[lmtf_pkg::ENTRIES-1]) begin
        res.evicted     = 1'b1;
        res.evicted_key = lmtf_pkg::TAG_BITS'(lru_keys[lmtf_pkg::ENTRIES-1]);
      end
      for (int i = lmtf_pkg::ENTRIES - 1; i > 0; i--) begin
        lru_keys[i]   = lru_keys[i-1];
        lru_values[i] = lru_values[i-1];
        lru_valid[i]  = lru_valid[i-1];
      end
      lru_keys[0]   = key;
      lru_values[0] = fill;
      lru_valid[0]  = 1'b1;
      res.value     = fill;
    end
    return res;
  endfunction

  function automatic void add_request(bit [lmtf_pkg::TAG_BITS-1:0] key,
                                      bit [lmtf_pkg::VAL_BITS-1:0] fill,
                                      bit ok, int gap, bit drain);
    cache_request_t req;
    req.key   = key;
    req.fill  = fill;
    req.ok    = ok;
    req.gap   = gap;
    req.drain = drain;
    request_q.push_back(req);
  endfunction

  function automatic void check_field(string name, bit [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Driver: pops requests, serves each one's gap, then holds the beat until
  // it is taken. The model advances on the edge that accepts the beat.
  cache_request_t cur_req;
  bit             have_cur = 1'b0;
  int             wait_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(cache_lookup(cur_req.key, cur_req.fill, cur_req.ok));
        have_cur = 1'b0;
      end
      if (!have_cur && request_q.size() > 0 &&
          !(request_q[0].drain && expected_results.size() > 0)) begin
        cur_req  = request_q.pop_front();
        have_cur = 1'b1;
        wait_cnt = cur_req.gap;
      end
      if (have_cur && wait_cnt > 0) begin
        wait_cnt--;
        s_axis_tvalid <= 1'b0;
      end else if (have_cur) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_req.fill, cur_req.key};
        s_axis_tuser  <= cur_req.ok;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once a few hundred results have passed,
  // so that the cache backs up and drops its input ready.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_left <= 120;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each accepted result beat against the oldest expectation
  // and draws a stall after every beat, except in calm stretches.
  cache_result_t exp_res;
  int            stall_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("hit", 64'(exp_res.hit), 64'(m_axis_tuser[0]));
          check_field("status", 64'(exp_res.status), 64'(m_axis_tuser[1]));
          check_field("evicted", 64'(exp_res.evicted), 64'(m_axis_tuser[2]));
          check_field("evicted_key", 64'(exp_res.evicted_key), 64'(m_axis_tdata[95:64]));
          check_field("value_out", exp_res.value, m_axis_tdata[63:0]);
        end
        results_seen <= results_seen + 1;
        stall_cnt = ((results_seen / 100) % 5 == 2) ? 0 : $urandom_range(0, 6);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      m_axis_tready <= (stall_cnt == 0) && (hold_left == 0);
    end
  end

  // Stimulus and end of run.
  initial begin
    bit [lmtf_pkg::TAG_BITS-1:0] pool[64];
    int                          pool_size;
    bit [lmtf_pkg::TAG_BITS-1:0] key;

    // Directed part. Empty list: insert, failed fill, insert with extreme keys.
    add_request('0, '1, 1'b1, $urandom_range(0, 6), 1'b0);
    add_request('1, '0, 1'b0, $urandom_range(0, 6), 1'b0);
    add_request('1, '1, 1'b1, $urandom_range(0, 6), 1'b0);
    // Hit with a failed fill flag: the flag must be ignored.
    add_request('0, {$urandom, $urandom}, 1'b0, $urandom_range(0, 6), 1'b0);
    // Fill the list; the last insert evicts the all-ones key.
    for (int i = 1; i <= lmtf_pkg::ENTRIES - 1; i++)
      add_request(32'h1 << (4 * i), {$urandom, $urandom}, 1'b1, $urandom_range(0, 6), 1'b0);
    // Hit on the least recently used slot, then a failed fill on a full list.
    add_request('0, '0, 1'b1, $urandom_range(0, 6), 1'b0);
    add_request(32'hA5A5_A5A5, '1, 1'b0, $urandom_range(0, 6), 1'b0);
    // Insert with a zero value that evicts, then hit it at the front.
    add_request(32'h5A5A_5A5A, '0, 1'b1, $urandom_range(0, 6), 1'b0);
    add_request(32'h5A5A_5A5A, '1, 1'b0, $urandom_range(0, 6), 1'b0);

    // Random part: phases with key pools smaller than, equal to, just above
    // and well above the list depth, so that hits, moves and evictions mix.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: pool_size = 3;
        1: pool_size = lmtf_pkg::ENTRIES;
        2: pool_size = lmtf_pkg::ENTRIES + 1;
        3: pool_size = 2 * lmtf_pkg::ENTRIES;
        default: pool_size = 64;
      endcase
      for (int j = 0; j < pool_size; j++) pool[j] = $urandom;
      for (int n = 0; n < 170; n++) begin
        key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
        add_request(key, {$urandom, $urandom}, $urandom_range(0, 6) != 0,
                    (p == 2 && n < 60) ? 0 : $urandom_range(0, 6),
                    n == 0 && (p == 1 || p == 3));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (request_q.size() > 0 || have_cur || expected_results.size() > 0);
    repeat (4 * lmtf_pkg::ENTRIES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lmtf_pkg.sv
rtl/lmtf_store.sv
rtl/lmtf_ctrl.sv
rtl/lru_move_to_front_cache.sv
dv/lru_move_to_front_cache_test.sv
